FILE: hdl/tts_pkg.sv
`default_nettype none
// ============================================================================
// tts_pkg
// Segment codes, decimal digit decoder and reciprocal constants shared by the
// temperature display decoder.
// ============================================================================
package tts_pkg;

    // Segment encoding: bit 7 decimal point, bits 0..6 segments a..g.
    localparam logic [7:0] SEG_DP     = 8'h80;
    localparam logic [7:0] SEG_MINUS  = 8'h40;
    localparam logic [7:0] SEG_E      = 8'h79;
    localparam logic [7:0] SEG_R      = 8'h31;
    localparam logic [7:0] SEG_BLANK  = 8'h00;
    localparam logic [7:0] UNIT_RESET = 8'h71;

    // Width of the magnitude used for digit extraction. Every displayed
    // reading has a magnitude below 10000, so 14 bits are enough.
    localparam int MAG_W = 14;

    // Reciprocals for division by 10, 100 and 1000. Each is exact for any
    // 14-bit magnitude when the product is shifted right by the given amount.
    localparam logic [17:0] RECIP_TEN      = 18'd52429;
    localparam int          SHIFT_TEN      = 19;
    localparam logic [17:0] RECIP_HUNDRED  = 18'd167773;
    localparam int          SHIFT_HUNDRED  = 24;
    localparam logic [17:0] RECIP_THOUSAND = 18'd16778;
    localparam int          SHIFT_THOUSAND = 24;

    typedef logic [7:0] seg_t;

    // Segment pattern of one decimal digit; codes above nine show blank.
    function automatic seg_t seg_of(input logic [3:0] digit);
        seg_t pattern;
        case (digit)
            4'd0:    pattern = 8'h3F;
            4'd1:    pattern = 8'h06;
            4'd2:    pattern = 8'h5B;
            4'd3:    pattern = 8'h4F;
            4'd4:    pattern = 8'h66;
            4'd5:    pattern = 8'h6D;
            4'd6:    pattern = 8'h7D;
            4'd7:    pattern = 8'h07;
            4'd8:    pattern = 8'h7F;
            4'd9:    pattern = 8'h67;
            default: pattern = SEG_BLANK;
        endcase
        return pattern;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/temperature_to_seven_segment.sv
`default_nettype none
// ============================================================================
// temperature_to_seven_segment
// Converts a signed temperature in tenths of a degree into the four segment
// patterns of a four-position seven-segment display.
// ============================================================================
//
//  Channel   Signals                              Direction  Handshake
//  -------   -----------------------------------  ---------  ----------------
//  command   start, busy, temp_tenths             in         start & !busy
//  result    done, digit_one..digit_four,         out        done (1 cycle)
//            out_of_range
//  config    cfg_valid, cfg_ready, cfg_data       in         valid & ready
//
//  A reading accepted at one edge is captured in the input register; its
//  result word is decoded into the result register and held on the result
//  ports, done being high for a single cycle; one reading is taken every cycle.
//  The rate is set by the single decode pass between the two registers
//  (three reciprocal multiplications by constants in parallel).
//  busy never rises and the receiver cannot stall, so nothing backs up.
//  Reset clears the valid flags and loads the unit letter F.
//
module temperature_to_seven_segment (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Command channel
    input  wire logic              start,
    output      logic              busy,
    input  wire logic signed [15:0] temp_tenths,
    // Result channel
    output      logic              done,
    output      tts_pkg::seg_t     digit_one,
    output      tts_pkg::seg_t     digit_two,
    output      tts_pkg::seg_t     digit_three,
    output      tts_pkg::seg_t     digit_four,
    output      logic              out_of_range,
    // Configuration channel
    input  wire logic              cfg_valid,
    output      logic              cfg_ready,
    input  wire logic [7:0]        cfg_data
);
    import tts_pkg::*;

    logic               in_valid_reg;
    logic signed [15:0] temp_reg;
    logic [7:0]         unit_reg;

    logic [15:0]        mag_full;
    logic [MAG_W-1:0]   mag;
    logic [31:0]        prod_ten;
    logic [31:0]        prod_hundred;
    logic [31:0]        prod_thousand;
    logic [10:0]        q_ten;
    logic [7:0]         q_hundred;
    logic [4:0]         q_thousand;
    logic [MAG_W-1:0]   ten_q_ten;
    logic [MAG_W-1:0]   rem_units;
    logic [10:0]        ten_q_hundred;
    logic [10:0]        rem_tens;
    logic [7:0]         ten_q_thousand;
    logic [7:0]         rem_hundreds;
    logic [3:0]         dig_tenths;
    logic [3:0]         dig_units;
    logic [3:0]         dig_tens;
    logic [3:0]         dig_hundreds;

    seg_t               d1_next;
    seg_t               d2_next;
    seg_t               d3_next;
    seg_t               d4_next;
    logic               err_next;

    seg_t               d1_reg;
    seg_t               d2_reg;
    seg_t               d3_reg;
    seg_t               d4_reg;
    logic               err_reg;
    logic               done_reg;

    // The block never refuses a reading or a configuration word.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Unit letter register, written from the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= UNIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unit_reg <= cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            temp_reg <= temp_tenths;
        end
    end

    // Magnitude; only its low bits matter for any reading that is shown.
    assign mag_full = temp_reg[15] ? 16'(-temp_reg) : 16'(temp_reg);
    assign mag      = mag_full[MAG_W-1:0];

    // Quotients by 10, 100 and 1000 through reciprocal multiplication.
    assign prod_ten      = {18'd0, mag} * {14'd0, RECIP_TEN};
    assign prod_hundred  = {18'd0, mag} * {14'd0, RECIP_HUNDRED};
    assign prod_thousand = {18'd0, mag} * {14'd0, RECIP_THOUSAND};

    assign q_ten      = prod_ten[SHIFT_TEN +: 11];
    assign q_hundred  = prod_hundred[SHIFT_HUNDRED +: 8];
    assign q_thousand = prod_thousand[SHIFT_THOUSAND +: 5];

    // Decimal digits as remainders against ten times the next quotient.
    assign ten_q_ten      = {q_ten, 3'b000} + {2'b00, q_ten, 1'b0};
    assign rem_units      = mag - ten_q_ten;
    assign ten_q_hundred  = {q_hundred, 3'b000} + {2'b00, q_hundred, 1'b0};
    assign rem_tens       = q_ten - ten_q_hundred;
    assign ten_q_thousand = {q_thousand, 3'b000} + {2'b00, q_thousand, 1'b0};
    assign rem_hundreds   = q_hundred - ten_q_thousand;

    assign dig_tenths   = rem_units[3:0];
    assign dig_units    = rem_tens[3:0];
    assign dig_tens     = rem_hundreds[3:0];
    assign dig_hundreds = q_thousand[3:0];

    // Layout selection by range of the reading.
    always_comb
    begin
        d1_next  = SEG_E;
        d2_next  = SEG_R;
        d3_next  = SEG_R;
        d4_next  = SEG_BLANK;
        err_next = 1'b1;
        if (temp_reg >= 16'sd0 && temp_reg <= 16'sd999)
        begin
            d1_next  = (dig_tens != 4'd0) ? seg_of(dig_tens) : SEG_BLANK;
            d2_next  = seg_of(dig_units) | SEG_DP;
            d3_next  = seg_of(dig_tenths);
            d4_next  = unit_reg;
            err_next = 1'b0;
        end
        else if (temp_reg >= -16'sd999 && temp_reg < 16'sd0)
        begin
            d1_next = SEG_MINUS;
            if (temp_reg > -16'sd100)
            begin
                d2_next = seg_of(dig_units) | SEG_DP;
                d3_next = seg_of(dig_tenths);
            end
            else
            begin
                d2_next = seg_of(dig_tens);
                d3_next = seg_of(dig_units);
            end
            d4_next  = unit_reg;
            err_next = 1'b0;
        end
        else if (temp_reg >= 16'sd1000 && temp_reg <= 16'sd9990)
        begin
            d1_next  = seg_of(dig_hundreds);
            d2_next  = seg_of(dig_tens);
            d3_next  = seg_of(dig_units);
            d4_next  = unit_reg;
            err_next = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            d1_reg  <= d1_next;
            d2_reg  <= d2_next;
            d3_reg  <= d3_next;
            d4_reg  <= d4_next;
            err_reg <= err_next;
        end
    end

    assign done         = done_reg;
    assign digit_one    = d1_reg;
    assign digit_two    = d2_reg;
    assign digit_three  = d3_reg;
    assign digit_four   = d4_reg;
    assign out_of_range = err_reg;

endmodule
`default_nettype wire
